[hw/rtl/assert_macros.svh]
// Assertion helpers used by host_port_string_parser.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, ignored while reset is high.
`define ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");

// Implication in the next cycle, checked through reset too.
`define ASSERT_NEXT(label, clk, lhs, rhs) \
   label: assert property (@(posedge clk) (lhs) |=> (rhs)) \
      else $error("assertion failed");

`endif

[hw/rtl/hpsp_pkg.sv]
`default_nettype none
package hpsp_pkg;

   typedef enum logic [4:0] {
      PH_START  = 5'b00001,
      PH_BHOST  = 5'b00010,
      PH_BCLOSE = 5'b00100,
      PH_PHOST  = 5'b01000,
      PH_PORT   = 5'b10000
   } phase_type;

   typedef struct packed {
      logic        host_byte_valid;
      logic [7:0]  host_byte;
      logic [7:0]  host_index;
      logic        done_res;
      logic        parse_ok;
      logic [15:0] port_number;
      logic [7:0]  host_length;
   } result_type;

   localparam logic [7:0]  CHR_NUL     = 8'h00;
   localparam logic [7:0]  CHR_LBRACK  = 8'h5B;
   localparam logic [7:0]  CHR_RBRACK  = 8'h5D;
   localparam logic [7:0]  CHR_COLON   = 8'h3A;
   localparam logic [7:0]  CHR_ZERO    = 8'h30;
   localparam logic [7:0]  CHR_NINE    = 8'h39;
   localparam logic [19:0] PORT_MAX    = 20'd65535;
   localparam logic [19:0] RADIX       = 20'd10;
   localparam logic [7:0]  CAP_RESET   = 8'd64;

endpackage
`default_nettype wire

[hw/rtl/host_port_string_parser.sv]
// Each input beat passes through the input register and then the result register.
// Throughput: one byte per cycle while results drain; the parser state updates once per byte.
// Reset (synchronous, active high) empties both registers, returns the parser to the
// start of a string and sets the host capacity to 64.
`default_nettype none
`include "assert_macros.svh"
module host_port_string_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [7:0]  csr_wr_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_text_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_host_byte_valid,
   output logic [7:0]       rsp_host_byte,
   output logic [7:0]       rsp_host_index,
   output logic             rsp_done_res,
   output logic             rsp_parse_ok,
   output logic [15:0]      rsp_port_number,
   output logic [7:0]       rsp_host_length
);

   logic                 out_ready;
   logic                 step_en;
   logic [7:0]           step_byte;
   hpsp_pkg::result_type result;
   hpsp_pkg::result_type rsp_ff;
   logic                 rsp_valid_ff, rsp_valid_in;

   assign out_ready = !rsp_valid_ff || rsp_ready;

   hpsp_input_reg u_input (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_text_byte (req_text_byte),
      .out_ready     (out_ready),
      .step_en       (step_en),
      .step_byte     (step_byte)
   );

   hpsp_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .step_en     (step_en),
      .step_byte   (step_byte),
      .result      (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // load a fresh result only when the previous beat has gone
   always_ff @(posedge clock) begin
      if (step_en) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_host_byte_valid = rsp_ff.host_byte_valid;
   assign rsp_host_byte       = rsp_ff.host_byte;
   assign rsp_host_index      = rsp_ff.host_index;
   assign rsp_done_res        = rsp_ff.done_res;
   assign rsp_parse_ok        = rsp_ff.parse_ok;
   assign rsp_port_number     = rsp_ff.port_number;
   assign rsp_host_length     = rsp_ff.host_length;

   `ASSERT_NEXT(a_reset_empties_output, clock, reset, !rsp_valid)
   `ASSERT_IMPLY(a_stall_only_when_full, clock, reset, !req_ready, rsp_valid && !rsp_ready)
   `ASSERT_IMPLY(a_ok_means_done_port, clock, reset, rsp_valid && rsp_parse_ok, rsp_done_res && rsp_port_number != 16'd0 && !rsp_host_byte_valid)

endmodule
`default_nettype wire

[hw/rtl/hpsp_input_reg.sv]
`default_nettype none
module hpsp_input_reg (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_text_byte,
   input  wire logic       out_ready,
   output logic            step_en,
   output logic [7:0]      step_byte
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       accept;

   assign step_en   = valid_ff && out_ready;
   assign req_ready = !valid_ff || out_ready;
   assign accept    = req_valid && req_ready;
   assign step_byte = byte_ff;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (step_en) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // hold the beat until the parser takes it
   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_text_byte;
      end
   end

endmodule
`default_nettype wire

[hw/rtl/hpsp_parser.sv]
`default_nettype none
module hpsp_parser (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_wr_en,
   input  wire logic [7:0] csr_wr_data,
   input  wire logic       step_en,
   input  wire logic [7:0] step_byte,
   output hpsp_pkg::result_type result
);

   hpsp_pkg::phase_type phase_ff, phase_in;
   logic        failed_ff, failed_in;
   logic [7:0]  count_ff, count_in;
   logic [15:0] accum_ff, accum_in;
   logic        digit_seen_ff, digit_seen_in;
   logic [7:0]  cap_ff;

   always_comb begin
      hpsp_pkg::phase_type work_phase;
      logic [8:0]  count_inc;
      logic        host_room;
      logic        take_host;
      logic        is_digit;
      logic [19:0] accum_next;

      phase_in      = phase_ff;
      failed_in     = failed_ff;
      count_in      = count_ff;
      accum_in      = accum_ff;
      digit_seen_in = digit_seen_ff;
      result        = '0;
      work_phase    = phase_ff;
      take_host     = 1'b0;

      count_inc  = {1'b0, count_ff} + 9'd1;
      host_room  = count_inc < {1'b0, cap_ff};
      is_digit   = (step_byte >= hpsp_pkg::CHR_ZERO) && (step_byte <= hpsp_pkg::CHR_NINE);
      accum_next = {4'b0, accum_ff} * hpsp_pkg::RADIX + {16'b0, step_byte[3:0]};

      if (step_byte == hpsp_pkg::CHR_NUL) begin
         result.done_res = 1'b1;
         if (!failed_ff && phase_ff == hpsp_pkg::PH_PORT && digit_seen_ff
             && accum_ff != 16'd0) begin
            result.parse_ok    = 1'b1;
            result.port_number = accum_ff;
            result.host_length = count_ff;
         end
         phase_in      = hpsp_pkg::PH_START;
         failed_in     = 1'b0;
         count_in      = 8'd0;
         accum_in      = 16'd0;
         digit_seen_in = 1'b0;
      end else if (!failed_ff) begin
         if (phase_ff == hpsp_pkg::PH_START) begin
            work_phase = (step_byte == hpsp_pkg::CHR_LBRACK) ? hpsp_pkg::PH_START
                                                             : hpsp_pkg::PH_PHOST;
            phase_in   = (step_byte == hpsp_pkg::CHR_LBRACK) ? hpsp_pkg::PH_BHOST
                                                             : hpsp_pkg::PH_PHOST;
         end
         unique case (work_phase)
            hpsp_pkg::PH_START: begin
               // opening bracket consumed, nothing more to do
            end
            hpsp_pkg::PH_BHOST: begin
               if (step_byte == hpsp_pkg::CHR_RBRACK) begin
                  if (count_ff == 8'd0 || count_ff >= cap_ff) begin
                     failed_in = 1'b1;
                  end else begin
                     phase_in = hpsp_pkg::PH_BCLOSE;
                  end
               end else begin
                  take_host = 1'b1;
               end
            end
            hpsp_pkg::PH_BCLOSE: begin
               if (step_byte == hpsp_pkg::CHR_COLON) begin
                  phase_in = hpsp_pkg::PH_PORT;
               end else begin
                  failed_in = 1'b1;
               end
            end
            hpsp_pkg::PH_PHOST: begin
               if (step_byte == hpsp_pkg::CHR_COLON) begin
                  if (count_ff >= cap_ff) begin
                     failed_in = 1'b1;
                  end else begin
                     phase_in = hpsp_pkg::PH_PORT;
                  end
               end else begin
                  take_host = 1'b1;
               end
            end
            hpsp_pkg::PH_PORT: begin
               if (!is_digit) begin
                  failed_in = 1'b1;
               end else begin
                  digit_seen_in = 1'b1;
                  if (accum_next > hpsp_pkg::PORT_MAX) begin
                     failed_in = 1'b1;
                     accum_in  = 16'd0;
                  end else begin
                     accum_in = accum_next[15:0];
                  end
               end
            end
            default: begin
               failed_in = 1'b1;
            end
         endcase
         if (take_host) begin
            if (!host_room) begin
               failed_in = 1'b1;
            end else begin
               result.host_byte_valid = 1'b1;
               result.host_byte       = step_byte;
               result.host_index      = count_ff;
               count_in               = count_inc[7:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= hpsp_pkg::PH_START;
         failed_ff     <= 1'b0;
         count_ff      <= 8'd0;
         accum_ff      <= 16'd0;
         digit_seen_ff <= 1'b0;
      end else if (step_en) begin
         phase_ff      <= phase_in;
         failed_ff     <= failed_in;
         count_ff      <= count_in;
         accum_ff      <= accum_in;
         digit_seen_ff <= digit_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= hpsp_pkg::CAP_RESET;
      end else if (csr_wr_en) begin
         cap_ff <= csr_wr_data;
      end
   end

endmodule
`default_nettype wire

[bench/host_port_string_parser_test.sv]
module host_port_string_parser_test;

   typedef logic [7:0] text_type[$];

   localparam int HOLD_CYCLES  = 150;
   localparam int RANDOM_BYTES = 150;
   localparam int DRAIN_LIMIT  = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [7:0]  csr_wr_data = 8'd0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_text_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_host_byte_valid;
   logic [7:0]  rsp_host_byte;
   logic [7:0]  rsp_host_index;
   logic        rsp_done_res;
   logic        rsp_parse_ok;
   logic [15:0] rsp_port_number;
   logic [7:0]  rsp_host_length;

   // parser shadow state
   logic [7:0]          host_cap = hpsp_pkg::CAP_RESET;
   hpsp_pkg::phase_type prs_phase = hpsp_pkg::PH_START;
   bit                  prs_failed = 1'b0;
   logic [7:0]          prs_count = 8'd0;
   int unsigned         prs_port = 0;
   bit                  prs_digit = 1'b0;

   hpsp_pkg::result_type pending_parse_results[$];

   int mismatch_count = 0;
   int bytes_sent = 0;
   int texts_sent = 0;
   int verdicts_ok = 0;
   int caps_written = 0;
   int results_seen = 0;
   bit quiet = 1'b0;
   int hold_orders = 0;
   int hold_taken = 0;
   int hold_left = 0;
   int stall_left = 0;

   always #5 clock = ~clock;

   host_port_string_parser dut (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_text_byte       (req_text_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_host_byte_valid (rsp_host_byte_valid),
      .rsp_host_byte       (rsp_host_byte),
      .rsp_host_index      (rsp_host_index),
      .rsp_done_res        (rsp_done_res),
      .rsp_parse_ok        (rsp_parse_ok),
      .rsp_port_number     (rsp_port_number),
      .rsp_host_length     (rsp_host_length)
   );

   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(11, 30);
   endfunction

   function automatic void take_host_byte(input logic [7:0] b,
                                          inout hpsp_pkg::result_type r);
      if (int'(prs_count) + 1 >= int'(host_cap)) begin
         prs_failed = 1'b1;
      end else begin
         r.host_byte_valid = 1'b1;
         r.host_byte = b;
         r.host_index = prs_count;
         prs_count = prs_count + 8'd1;
      end
   endfunction

   function automatic hpsp_pkg::result_type parse_next_byte(input logic [7:0] b);
      hpsp_pkg::result_type r;
      r = '0;
      if (b == hpsp_pkg::CHR_NUL) begin
         r.done_res = 1'b1;
         if (!prs_failed && prs_phase == hpsp_pkg::PH_PORT && prs_digit && prs_port != 0) begin
            r.parse_ok = 1'b1;
            r.port_number = prs_port[15:0];
            r.host_length = prs_count;
         end
         prs_phase = hpsp_pkg::PH_START;
         prs_failed = 1'b0;
         prs_count = 8'd0;
         prs_port = 0;
         prs_digit = 1'b0;
         return r;
      end
      if (prs_failed) return r;
      if (prs_phase == hpsp_pkg::PH_START) begin
         if (b == hpsp_pkg::CHR_LBRACK) begin
            prs_phase = hpsp_pkg::PH_BHOST;
            return r;
         end
         prs_phase = hpsp_pkg::PH_PHOST;
      end
      case (prs_phase)
         hpsp_pkg::PH_BHOST: begin
            if (b == hpsp_pkg::CHR_RBRACK) begin
               if (prs_count == 0 || prs_count >= host_cap) prs_failed = 1'b1;
               else prs_phase = hpsp_pkg::PH_BCLOSE;
            end else begin
               take_host_byte(b, r);
            end
         end
         hpsp_pkg::PH_BCLOSE: begin
            if (b == hpsp_pkg::CHR_COLON) prs_phase = hpsp_pkg::PH_PORT;
            else prs_failed = 1'b1;
         end
         hpsp_pkg::PH_PHOST: begin
            if (b == hpsp_pkg::CHR_COLON) begin
               if (prs_count >= host_cap) prs_failed = 1'b1;
               else prs_phase = hpsp_pkg::PH_PORT;
            end else begin
               take_host_byte(b, r);
            end
         end
         hpsp_pkg::PH_PORT: begin
            if (b < hpsp_pkg::CHR_ZERO || b > hpsp_pkg::CHR_NINE) begin
               prs_failed = 1'b1;
            end else begin
               prs_port = prs_port * hpsp_pkg::RADIX + (b - hpsp_pkg::CHR_ZERO);
               prs_digit = 1'b1;
               if (prs_port > hpsp_pkg::PORT_MAX) begin
                  prs_failed = 1'b1;
                  prs_port = 0;
               end
            end
         end
         default: prs_failed = 1'b1;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $time, msg);
   endtask

   task automatic compare_field(input string name, input logic [15:0] got,
                                input logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                   results_seen, name, got, want));
   endtask

   task automatic check_result();
      hpsp_pkg::result_type want;
      if (pending_parse_results.size() == 0) begin
         report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                   results_seen));
         return;
      end
      want = pending_parse_results.pop_front();
      compare_field("host_byte_valid", 16'(rsp_host_byte_valid), 16'(want.host_byte_valid));
      compare_field("host_byte", 16'(rsp_host_byte), 16'(want.host_byte));
      compare_field("host_index", 16'(rsp_host_index), 16'(want.host_index));
      compare_field("done_res", 16'(rsp_done_res), 16'(want.done_res));
      compare_field("parse_ok", 16'(rsp_parse_ok), 16'(want.parse_ok));
      compare_field("port_number", rsp_port_number, want.port_number);
      compare_field("host_length", 16'(rsp_host_length), 16'(want.host_length));
   endtask

   // receiver: check each beat, then decide ready for the next edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         check_result();
         results_seen++;
      end
      if (hold_taken != hold_orders) begin
         hold_taken = hold_orders;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         stall_left = pick_gap();
         rsp_ready <= (stall_left == 0);
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      hpsp_pkg::result_type r;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_text_byte <= b;
      do @(posedge clock); while (!req_ready);
      r = parse_next_byte(b);
      pending_parse_results.push_back(r);
      bytes_sent++;
      if (r.done_res) texts_sent++;
      if (r.parse_ok) verdicts_ok++;
   endtask

   task automatic send_text(input text_type t);
      foreach (t[i]) send_byte(t[i]);
      send_byte(hpsp_pkg::CHR_NUL);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending_parse_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_capacity(input logic [7:0] cap);
      settle();
      csr_wr_data <= cap;
      csr_wr_en <= 1'b1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      host_cap = cap;
      caps_written++;
   endtask

   function automatic text_type text_of(input string s);
      text_type t;
      foreach (s[i]) t.push_back(s[i]);
      return t;
   endfunction

   function automatic logic [7:0] host_char(input bit bracketed);
      string common;
      logic [7:0] c;
      common = "abcdefghijklmnopqrstuvwxyz0123456789.-";
      if ($urandom_range(0, 9) < 7) return common[$urandom_range(0, common.len() - 1)];
      do c = 8'($urandom_range(1, 255));
      while (c == (bracketed ? hpsp_pkg::CHR_RBRACK : hpsp_pkg::CHR_COLON));
      return c;
   endfunction

   function automatic text_type make_text();
      text_type t;
      int kind;
      int hlen;
      int pos;
      bit br;
      string port;
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
         repeat ($urandom_range(0, 10)) t.push_back(8'($urandom_range(1, 255)));
         return t;
      end
      br = ($urandom_range(0, 1) == 1);
      // now and then push the host right up to the capacity
      if (host_cap <= 24 && $urandom_range(0, 4) == 0)
         hlen = int'(host_cap) - 2 + $urandom_range(0, 2);
      else
         hlen = $urandom_range(0, 6);
      if (hlen < 0) hlen = 0;
      if (br) t.push_back(hpsp_pkg::CHR_LBRACK);
      repeat (hlen) t.push_back(host_char(br));
      if (br) t.push_back(hpsp_pkg::CHR_RBRACK);
      t.push_back(hpsp_pkg::CHR_COLON);
      case ($urandom_range(0, 9))
         0, 1, 2, 3: port = $sformatf("%0d", $urandom_range(1, 65535));
         4: port = $sformatf("%0d", $urandom_range(1, 99));
         5: port = $urandom_range(0, 1) ? "0" : "000";
         6: port = "65535";
         7: port = $sformatf("%0d", $urandom_range(65536, 9999999));
         8: port = {"00", $sformatf("%0d", $urandom_range(1, 999))};
         default: port = "";
      endcase
      t = {t, text_of(port)};
      if (kind >= 85) begin
         pos = $urandom_range(0, t.size());
         case ($urandom_range(0, 3))
            0: t.insert(pos, hpsp_pkg::CHR_COLON);
            1: t.insert(pos, hpsp_pkg::CHR_RBRACK);
            2: t.insert(pos, 8'($urandom_range(1, 255)));
            default: if (pos < t.size()) t.delete(pos);
         endcase
      end
      return t;
   endfunction

   task automatic test_directed_texts();
      text_type t;
      send_text(text_of(""));
      t = text_of("x:0");
      t[0] = 8'hFF;
      send_text(t);
      send_text(text_of("[a]:9"));
      send_text(text_of("a"));
      send_text(text_of("::1"));
      send_text(text_of(":70000"));
      send_text(text_of("z:65535"));
   endtask

   task automatic test_capacity_limits();
      text_type t;
      set_capacity(8'd1);
      send_text(text_of(":1"));
      send_text(text_of("a:1"));
      send_text(text_of("[a]:1"));
      set_capacity(8'd2);
      send_text(text_of("[a]:1"));
      send_text(text_of("ab:1"));
      send_text(text_of("[]:1"));
      set_capacity(8'd255);
      repeat (254) t.push_back(host_char(1'b0));
      send_text({t, text_of(":1")});
      t = {hpsp_pkg::CHR_LBRACK};
      repeat (255) t.push_back(host_char(1'b1));
      send_text({t, text_of("]:2")});
   endtask

   task automatic test_random_texts();
      logic [7:0] caps[6];
      int budget;
      caps = '{8'd1, 8'd255, 8'd3, 8'($urandom_range(2, 16)),
               8'($urandom_range(1, 255)), hpsp_pkg::CAP_RESET};
      foreach (caps[k]) begin
         set_capacity(caps[k]);
         budget = bytes_sent + RANDOM_BYTES / 6;
         while (bytes_sent < budget) begin
            quiet = ($urandom_range(0, 7) == 0);
            send_text(make_text());
         end
      end
      quiet = 1'b0;
   endtask

   task automatic test_input_stall();
      settle();
      // hold the receiver off and offer beats back to back
      quiet = 1'b1;
      hold_orders++;
      send_text(text_of("[fe80::1]:443"));
      repeat (3) send_text(make_text());
      quiet = 1'b0;
   endtask

   initial begin
      int waited;
      waited = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_texts();
      test_capacity_limits();
      test_random_texts();
      test_input_stall();
      req_valid <= 1'b0;
      while (pending_parse_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (6) @(posedge clock);
      if (pending_parse_results.size() != 0)
         report_mismatch($sformatf("%0d results never arrived",
                                   pending_parse_results.size()));
      $display("Covered %0d texts in %0d bytes, %0d parsed ok, over %0d capacity writes,",
               texts_sent, bytes_sent, verdicts_ok, caps_written);
      $display("with random idling on both sides and one long receiver hold-off; %0d mismatches.",
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("** host_port_string_parser: PASSED **");
      end else begin
         $display("** host_port_string_parser: FAILED **");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Run timed out with %0d results outstanding.", pending_parse_results.size());
      $display("** host_port_string_parser: FAILED **");
      $finish;
   end

endmodule
